// ===== design/its_pkg.sv =====
// its_pkg: shared widths, reset values and register codes of the
// intercept time solver. No dependencies.
package its_pkg;

  // field widths of the words on the channels
  localparam int POS_W  = 32;
  localparam int TIME_W = 31;
  localparam int SPD_W  = 31;
  localparam int LIM_W  = 16;
  localparam int HIT_W  = 31;
  localparam int CFG_W  = 32;

  // digit width of one multiplier cell
  localparam int DIG = 32;

  localparam logic [HIT_W-1:0] HIT_MAX = '1;

  // register reset values
  localparam logic [SPD_W-1:0] SPD_RST = 31'd655360;
  localparam logic [LIM_W-1:0] LIM_RST = 16'd1;

  // configuration register index
  typedef enum logic [1:0] {
    CFG_LAUNCHER_X  = 2'd0,
    CFG_LAUNCHER_Y  = 2'd1,
    CFG_SHOT_SPEED  = 2'd2,
    CFG_DEGEN_LIMIT = 2'd3
  } cfg_idx_t;

endpackage

// ===== design/its_in_if.sv =====
// its_in_if: query channel of the intercept time solver.
// Depends on its_pkg for the field widths.
interface its_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [its_pkg::POS_W-1:0] target_x;
  logic signed [its_pkg::POS_W-1:0] target_y;
  logic signed [its_pkg::POS_W-1:0] target_vx;
  logic signed [its_pkg::POS_W-1:0] target_vy;
  logic [its_pkg::TIME_W-1:0]       launch_delay;

  modport source (output valid, target_x, target_y, target_vx, target_vy, launch_delay,
                  input ready);
  modport sink (input valid, target_x, target_y, target_vx, target_vy, launch_delay,
                output ready);
endinterface

// ===== design/its_out_if.sv =====
// its_out_if: result channel of the intercept time solver.
// Depends on its_pkg for the field widths.
interface its_out_if;
  logic                       valid;
  logic                       ready;
  logic                       solution_found;
  logic [its_pkg::HIT_W-1:0]  hit_time;

  modport source (output valid, solution_found, hit_time, input ready);
  modport sink (input valid, solution_found, hit_time, output ready);
endinterface

// ===== design/its_mul_cell.sv =====
// its_mul_cell: one digit-by-digit multiply-accumulate cell of the
// multiplier row. Depends on its_pkg for the digit width.
module its_mul_cell #(
  parameter int NDA = 1,
  parameter int NDB = 1,
  parameter int IA  = 0,
  parameter int IB  = 0,
  parameter int SW  = 1
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    en,
  input  logic                                    vld_i,
  input  logic [NDA*its_pkg::DIG-1:0]             a_i,
  input  logic [NDB*its_pkg::DIG-1:0]             b_i,
  input  logic [(NDA+NDB)*its_pkg::DIG-1:0]       acc_i,
  input  logic [SW-1:0]                           side_i,
  output logic                                    vld_o,
  output logic [NDA*its_pkg::DIG-1:0]             a_o,
  output logic [NDB*its_pkg::DIG-1:0]             b_o,
  output logic [(NDA+NDB)*its_pkg::DIG-1:0]       acc_o,
  output logic [SW-1:0]                           side_o
);
  localparam int D  = its_pkg::DIG;
  localparam int PW = (NDA + NDB) * D;

  logic [2*D-1:0] prod;
  logic [PW-1:0]  acc_nxt;
  logic           vld_r;
  logic [NDA*D-1:0] a_r;
  logic [NDB*D-1:0] b_r;
  logic [PW-1:0]  acc_r;
  logic [SW-1:0]  side_r;

  // one partial product, shifted to its digit position
  assign prod    = (2*D)'(a_i[IA*D +: D]) * (2*D)'(b_i[IB*D +: D]);
  assign acc_nxt = acc_i + (PW'(prod) << (D * (IA + IB)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a_i;
      b_r    <= b_i;
      acc_r  <= acc_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign a_o    = a_r;
  assign b_o    = b_r;
  assign acc_o  = acc_r;
  assign side_o = side_r;
endmodule

// ===== design/its_mul.sv =====
// its_mul: signed pipelined multiplier built as a row of its_mul_cell,
// one cell per digit pair, with sideband carried alongside.
// Depends on its_pkg and its_mul_cell.
module its_mul #(
  parameter int AW = 33,
  parameter int BW = 33,
  parameter int SW = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  input  logic [SW-1:0]           side_i,
  output logic                    vld_o,
  output logic signed [AW+BW-1:0] p_o,
  output logic [SW-1:0]           side_o
);
  localparam int D   = its_pkg::DIG;
  localparam int NDA = (AW + D - 1) / D;
  localparam int NDB = (BW + D - 1) / D;
  localparam int NC  = NDA * NDB;
  localparam int AMW = NDA * D;
  localparam int BMW = NDB * D;
  localparam int PW  = AMW + BMW;
  localparam int CSW = SW + 1;

  logic [AW-1:0]  a_abs;
  logic [BW-1:0]  b_abs;
  logic           vld0_r;
  logic [AMW-1:0] a0_r;
  logic [BMW-1:0] b0_r;
  logic [CSW-1:0] sd0_r;

  logic           vld_c [0:NC];
  logic [AMW-1:0] a_c   [0:NC];
  logic [BMW-1:0] b_c   [0:NC];
  logic [PW-1:0]  acc_c [0:NC];
  logic [CSW-1:0] sd_c  [0:NC];

  logic [PW-1:0]     p_mag;
  logic              vld_r;
  logic [AW+BW-1:0]  p_r;
  logic [SW-1:0]     side_r;

  // magnitudes and product sign
  assign a_abs = a_i[AW-1] ? AW'(-a_i) : AW'(a_i);
  assign b_abs = b_i[BW-1] ? BW'(-b_i) : BW'(b_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r  <= AMW'(a_abs);
      b0_r  <= BMW'(b_abs);
      sd0_r <= {side_i, a_i[AW-1] ^ b_i[BW-1]};
    end
  end

  assign vld_c[0] = vld0_r;
  assign a_c[0]   = a0_r;
  assign b_c[0]   = b0_r;
  assign acc_c[0] = '0;
  assign sd_c[0]  = sd0_r;

  // row of digit cells
  for (genvar k = 0; k < NC; k++) begin : g_cell
    its_mul_cell #(
      .NDA (NDA),
      .NDB (NDB),
      .IA  (k / NDB),
      .IB  (k % NDB),
      .SW  (CSW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (vld_c[k]),
      .a_i    (a_c[k]),
      .b_i    (b_c[k]),
      .acc_i  (acc_c[k]),
      .side_i (sd_c[k]),
      .vld_o  (vld_c[k+1]),
      .a_o    (a_c[k+1]),
      .b_o    (b_c[k+1]),
      .acc_o  (acc_c[k+1]),
      .side_o (sd_c[k+1])
    );
  end

  // restore the sign
  assign p_mag = sd_c[NC][0] ? (~acc_c[NC] + 1'b1) : acc_c[NC];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_c[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= p_mag[AW+BW-1:0];
      side_r <= sd_c[NC][CSW-1:1];
    end
  end

  assign vld_o  = vld_r;
  assign p_o    = p_r;
  assign side_o = side_r;
endmodule

// ===== design/its_sqrt_cell.sv =====
// its_sqrt_cell: one digit step of the integer square root row; takes
// two radicand bits and yields one root bit. No dependencies.
module its_sqrt_cell #(
  parameter int QW = 4,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic [QW-1:0]        rad_i,
  input  logic [QW/2+2:0]      rem_i,
  input  logic [QW/2-1:0]      root_i,
  input  logic [SW-1:0]        side_i,
  output logic                 vld_o,
  output logic [QW-1:0]        rad_o,
  output logic [QW/2+2:0]      rem_o,
  output logic [QW/2-1:0]      root_o,
  output logic [SW-1:0]        side_o
);
  localparam int RTW = QW / 2;
  localparam int RMW = RTW + 3;

  logic [RMW-1:0] rem2;
  logic [RMW-1:0] trial;
  logic           ge;
  logic           vld_r;
  logic [QW-1:0]  rad_r;
  logic [RMW-1:0] rem_r;
  logic [RTW-1:0] root_r;
  logic [SW-1:0]  side_r;

  // bring down two bits, try root*4+1
  assign rem2  = {rem_i[RMW-3:0], rad_i[QW-1 -: 2]};
  assign trial = RMW'({root_i, 2'b01});
  assign ge    = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_i << 2;
      rem_r  <= ge ? rem2 - trial : rem2;
      root_r <= {root_i[RTW-2:0], ge};
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;
endmodule

// ===== design/its_div_cell.sv =====
// its_div_cell: one restoring division step, one quotient bit per cell.
// Depends on its_pkg for the quotient width.
module its_div_cell #(
  parameter int RW = 64,
  parameter int SW = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      vld_i,
  input  logic [RW-1:0]             n_i,
  input  logic [RW-1:0]             d_i,
  input  logic [its_pkg::HIT_W-1:0] q_i,
  input  logic [SW-1:0]             side_i,
  output logic                      vld_o,
  output logic [RW-1:0]             n_o,
  output logic [RW-1:0]             d_o,
  output logic [its_pkg::HIT_W-1:0] q_o,
  output logic [SW-1:0]             side_o
);
  localparam int QBW = its_pkg::HIT_W;

  logic           ge;
  logic           vld_r;
  logic [RW-1:0]  n_r;
  logic [RW-1:0]  d_r;
  logic [QBW-1:0] q_r;
  logic [SW-1:0]  side_r;

  // subtract the shifted divisor when it fits
  assign ge = n_i >= d_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= ge ? n_i - d_i : n_i;
      d_r    <= d_i >> 1;
      q_r    <= {q_i[QBW-2:0], ge};
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign n_o    = n_r;
  assign d_o    = d_r;
  assign q_o    = q_r;
  assign side_o = side_r;
endmodule

// ===== design/intercept_time_solver_unit.sv =====
// intercept_time_solver_unit: projectile intercept time of a moving target.
// Depends on its_pkg, its_in_if, its_out_if, its_mul, its_sqrt_cell, its_div_cell.
//
// Usage
//   in_word carries one query: target position, velocity and launch delay,
//   all fixed point with FRAC_BITS fractional bits. out_word returns one
//   word per query: solution_found and hit_time (truncated, saturated,
//   zero when no positive root exists). Words leave in query order.
//   cfg_we/cfg_idx/cfg_data write the launcher position, shot speed and
//   degeneracy limit; write them only while no query is in flight.
// Timing
//   One query per cycle while the pipeline is not held. At FRAC_BITS = 16
//   the square root row (one cell per root bit, 97 cells) and the 16-cell
//   wide multiplier row make up most of the pipeline, the 31-cell divider
//   row the rest.
// Reset
//   rst_n clears the pipeline valid bits and loads the register defaults
//   (launcher at origin, speed 10.0, limit one raw unit).
// Stall
//   The whole pipeline holds while a result word waits and out_word.ready
//   is low; in_word.ready follows the same hold signal.
module intercept_time_solver_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  its_in_if.sink                      in_word,
  its_out_if.source                   out_word,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_idx,
  input  logic [its_pkg::CFG_W-1:0]   cfg_data
);
  localparam int V       = its_pkg::POS_W;
  localparam int HW      = its_pkg::HIT_W;
  localparam int LW      = its_pkg::LIM_W;
  localparam int RXW     = V + 1;
  localparam int AW      = 2 * V + 1;
  localparam int RVW     = 2 * V + 2;
  localparam int R2W     = 2 * V + 3;
  localparam int S2W     = 2 * V - 2;
  localparam int S2T0W   = 3 * V - 3;
  localparam int S2T0T0W = 4 * V - 4;
  localparam int BW      = ((RVW + FRAC_BITS > S2T0W + 1) ? RVW + FRAC_BITS : S2T0W + 1) + 2;
  localparam int CW      = ((R2W + 2 * FRAC_BITS > S2T0T0W + 1) ?
                            R2W + 2 * FRAC_BITS : S2T0T0W + 1) + 1;
  localparam int MW      = (CW > BW) ? CW : BW;
  localparam int DW      = (2 * BW > AW + CW + 2) ? 2 * BW : AW + CW + 2;
  localparam int QW      = ((DW + 1) / 2) * 2;
  localparam int RTW     = QW / 2;
  localparam int RMW     = RTW + 3;
  localparam int XW      = CW + 1;
  localparam int YW      = (BW > AW + 1) ? BW : AW + 1;
  localparam int NXW     = ((XW > RTW + 1) ? XW : RTW + 1) + 1;
  localparam int RW      = YW + HW;
  localparam int SATW    = (NXW > RW) ? NXW : RW;

  typedef struct packed {
    logic signed [V-1:0] t0;
    logic [LW-1:0]       lim;
  } m1_side_t;

  typedef struct packed {
    logic signed [AW-1:0]  a;
    logic signed [RVW-1:0] rv;
    logic signed [R2W-1:0] r2;
    logic signed [V-1:0]   t0;
    logic [LW-1:0]         lim;
  } m2_side_t;

  typedef struct packed {
    logic signed [AW-1:0]    a;
    logic signed [RVW-1:0]   rv;
    logic signed [R2W-1:0]   r2;
    logic [LW-1:0]           lim;
    logic signed [S2T0W:0]   s2t0;
  } m3_side_t;

  typedef struct packed {
    logic signed [AW-1:0] a;
    logic signed [BW-1:0] b;
    logic signed [CW-1:0] c;
    logic [LW-1:0]        lim;
  } m4_side_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [YW-1:0] y;
    logic                 lin;
    logic                 bok;
    logic                 dneg;
  } sq_side_t;

  typedef struct packed {
    logic found;
    logic sat;
  } dv_side_t;

  // pipeline hold
  logic en;
  assign en = !out_word.valid || out_word.ready;
  assign in_word.ready = en;

  // configuration registers
  logic signed [V-1:0]          lx_r;
  logic signed [V-1:0]          ly_r;
  logic [its_pkg::SPD_W-1:0]    spd_r;
  logic [LW-1:0]                lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lx_r  <= '0;
      ly_r  <= '0;
      spd_r <= its_pkg::SPD_RST;
      lim_r <= its_pkg::LIM_RST;
    end else if (cfg_we) begin
      unique case (its_pkg::cfg_idx_t'(cfg_idx))
        its_pkg::CFG_LAUNCHER_X:  lx_r  <= cfg_data;
        its_pkg::CFG_LAUNCHER_Y:  ly_r  <= cfg_data;
        its_pkg::CFG_SHOT_SPEED:  spd_r <= cfg_data[its_pkg::SPD_W-1:0];
        its_pkg::CFG_DEGEN_LIMIT: lim_r <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // input stage: relative position
  logic                  s0_vld_r;
  logic signed [RXW-1:0] rx0_r, ry0_r;
  logic signed [V-1:0]   vx0_r, vy0_r, t00_r, sp0_r;
  logic [LW-1:0]         lim0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx0_r  <= RXW'(in_word.target_x) - RXW'(lx_r);
      ry0_r  <= RXW'(in_word.target_y) - RXW'(ly_r);
      vx0_r  <= in_word.target_vx;
      vy0_r  <= in_word.target_vy;
      t00_r  <= {1'b0, in_word.launch_delay};
      sp0_r  <= {1'b0, spd_r};
      lim0_r <= lim_r;
    end
  end

  // first multiplier bank: squares and dot products
  logic                      m1_vld;
  m1_side_t                  m1_si, m1_so;
  logic signed [2*RXW-1:0]   p_vxvx, p_vyvy, p_rxvx, p_ryvy, p_rxrx, p_ryry, p_ss;

  assign m1_si = '{t0: t00_r, lim: lim0_r};

  its_mul #(.AW(RXW), .BW(RXW), .SW($bits(m1_side_t))) u_m_vxvx (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(s0_vld_r),
    .a_i(RXW'(vx0_r)), .b_i(RXW'(vx0_r)), .side_i(m1_si),
    .vld_o(m1_vld), .p_o(p_vxvx), .side_o(m1_so));
  its_mul #(.AW(RXW), .BW(RXW), .SW(1)) u_m_vyvy (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(1'b0),
    .a_i(RXW'(vy0_r)), .b_i(RXW'(vy0_r)), .side_i(1'b0),
    .vld_o(), .p_o(p_vyvy), .side_o());
  its_mul #(.AW(RXW), .BW(RXW), .SW(1)) u_m_rxvx (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(1'b0),
    .a_i(rx0_r), .b_i(RXW'(vx0_r)), .side_i(1'b0),
    .vld_o(), .p_o(p_rxvx), .side_o());
  its_mul #(.AW(RXW), .BW(RXW), .SW(1)) u_m_ryvy (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(1'b0),
    .a_i(ry0_r), .b_i(RXW'(vy0_r)), .side_i(1'b0),
    .vld_o(), .p_o(p_ryvy), .side_o());
  its_mul #(.AW(RXW), .BW(RXW), .SW(1)) u_m_rxrx (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(1'b0),
    .a_i(rx0_r), .b_i(rx0_r), .side_i(1'b0),
    .vld_o(), .p_o(p_rxrx), .side_o());
  its_mul #(.AW(RXW), .BW(RXW), .SW(1)) u_m_ryry (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(1'b0),
    .a_i(ry0_r), .b_i(ry0_r), .side_i(1'b0),
    .vld_o(), .p_o(p_ryry), .side_o());
  its_mul #(.AW(RXW), .BW(RXW), .SW(1)) u_m_ss (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(1'b0),
    .a_i(RXW'(sp0_r)), .b_i(RXW'(sp0_r)), .side_i(1'b0),
    .vld_o(), .p_o(p_ss), .side_o());

  // sums: a, r.v, |r|^2, s^2
  logic                  s1_vld_r;
  logic signed [AW-1:0]  a1_r;
  logic signed [RVW-1:0] rv1_r;
  logic signed [R2W-1:0] r21_r;
  logic signed [S2W:0]   s21_r;
  logic signed [V-1:0]   t01_r;
  logic [LW-1:0]         lim1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= AW'(p_vxvx + p_vyvy - p_ss);
      rv1_r  <= RVW'(p_rxvx + p_ryvy);
      r21_r  <= R2W'(p_rxrx) + R2W'(p_ryry);
      s21_r  <= p_ss[S2W:0];
      t01_r  <= m1_so.t0;
      lim1_r <= m1_so.lim;
    end
  end

  // s^2 * t0
  logic                        m2_vld;
  m2_side_t                    m2_si, m2_so;
  logic signed [S2W+V:0]       p_s2t0;

  assign m2_si = '{a: a1_r, rv: rv1_r, r2: r21_r, t0: t01_r, lim: lim1_r};

  its_mul #(.AW(S2W+1), .BW(V), .SW($bits(m2_side_t))) u_m_s2t0 (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(s1_vld_r),
    .a_i(s21_r), .b_i(t01_r), .side_i(m2_si),
    .vld_o(m2_vld), .p_o(p_s2t0), .side_o(m2_so));

  // s^2 * t0 * t0
  logic                        m3_vld;
  m3_side_t                    m3_si, m3_so;
  logic signed [S2T0W+V:0]     p_s2t0t0;

  assign m3_si = '{a: m2_so.a, rv: m2_so.rv, r2: m2_so.r2, lim: m2_so.lim,
                   s2t0: p_s2t0[S2T0W:0]};

  its_mul #(.AW(S2T0W+1), .BW(V), .SW($bits(m3_side_t))) u_m_s2t0t0 (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(m2_vld),
    .a_i(p_s2t0[S2T0W:0]), .b_i(m2_so.t0), .side_i(m3_si),
    .vld_o(m3_vld), .p_o(p_s2t0t0), .side_o(m3_so));

  // coefficients b and c
  logic                    s3_vld_r;
  logic signed [AW-1:0]    a3_r;
  logic signed [BW-1:0]    b3_r;
  logic signed [CW-1:0]    c3_r;
  logic [LW-1:0]           lim3_r;
  logic signed [S2T0T0W:0] s2t0t0;

  assign s2t0t0 = p_s2t0t0[S2T0T0W:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= m3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a3_r   <= m3_so.a;
      b3_r   <= ((BW'(m3_so.rv) <<< FRAC_BITS) - BW'(m3_so.s2t0)) <<< 1;
      c3_r   <= (CW'(m3_so.r2) <<< (2 * FRAC_BITS)) - CW'(s2t0t0);
      lim3_r <= m3_so.lim;
    end
  end

  // b^2 and a*c
  logic                  m4_vld;
  m4_side_t              m4_si, m4_so;
  logic signed [2*MW-1:0] p_bb, p_ac;

  assign m4_si = '{a: a3_r, b: b3_r, c: c3_r, lim: lim3_r};

  its_mul #(.AW(MW), .BW(MW), .SW($bits(m4_side_t))) u_m_bb (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(s3_vld_r),
    .a_i(MW'(b3_r)), .b_i(MW'(b3_r)), .side_i(m4_si),
    .vld_o(m4_vld), .p_o(p_bb), .side_o(m4_so));
  its_mul #(.AW(MW), .BW(MW), .SW(1)) u_m_ac (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(1'b0),
    .a_i(MW'(a3_r)), .b_i(MW'(c3_r)), .side_i(1'b0),
    .vld_o(), .p_o(p_ac), .side_o());

  // discriminant and degeneracy tests
  logic signed [DW-1:0] d4;
  logic [AW-1:0]        a_abs;
  logic [BW-1:0]        b_abs;
  logic                 a_small, b_ok;
  logic                 s4_vld_r;
  logic [QW-1:0]        rad4_r;
  sq_side_t             sq4_r;

  assign d4      = DW'(p_bb) - (DW'(p_ac) <<< 2);
  assign a_abs   = m4_so.a[AW-1] ? AW'(-m4_so.a) : AW'(m4_so.a);
  assign b_abs   = m4_so.b[BW-1] ? BW'(-m4_so.b) : BW'(m4_so.b);
  assign a_small = (m4_so.a == '0) || (a_abs < (AW'(m4_so.lim) << FRAC_BITS));
  assign b_ok    = (m4_so.b != '0) && (b_abs >= (BW'(m4_so.lim) << (2 * FRAC_BITS)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= m4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad4_r     <= d4[DW-1] ? '0 : QW'(d4);
      sq4_r.x    <= a_small ? -(XW'(m4_so.c)) : -(XW'(m4_so.b));
      sq4_r.y    <= a_small ? YW'(m4_so.b) : (YW'(m4_so.a) <<< 1);
      sq4_r.lin  <= a_small;
      sq4_r.bok  <= b_ok;
      sq4_r.dneg <= d4[DW-1];
    end
  end

  // square root row
  logic             sq_vld  [0:RTW];
  logic [QW-1:0]    sq_rad  [0:RTW];
  logic [RMW-1:0]   sq_rem  [0:RTW];
  logic [RTW-1:0]   sq_root [0:RTW];
  sq_side_t         sq_sd   [0:RTW];

  assign sq_vld[0]  = s4_vld_r;
  assign sq_rad[0]  = rad4_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_sd[0]   = sq4_r;

  for (genvar k = 0; k < RTW; k++) begin : g_sqrt
    its_sqrt_cell #(.QW(QW), .SW($bits(sq_side_t))) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(sq_vld[k]), .rad_i(sq_rad[k]), .rem_i(sq_rem[k]),
      .root_i(sq_root[k]), .side_i(sq_sd[k]),
      .vld_o(sq_vld[k+1]), .rad_o(sq_rad[k+1]), .rem_o(sq_rem[k+1]),
      .root_o(sq_root[k+1]), .side_o(sq_sd[k+1]));
  end

  // root selection
  sq_side_t              sq5;
  logic signed [RTW:0]   sq_s;
  logic signed [NXW-1:0] n1, n2, xn, num_sel;
  logic                  ysg, p1, p2, fnd5;
  logic [NXW-1:0]        num_abs;
  logic [YW-1:0]         den_abs;
  logic                  s5_vld_r, fnd5_r;
  logic [NXW-1:0]        num5_r;
  logic [YW-1:0]         den5_r;

  assign sq5  = sq_sd[RTW];
  assign sq_s = {1'b0, sq_root[RTW]};
  assign xn   = NXW'(sq5.x);
  assign n1   = xn + NXW'(sq_s);
  assign n2   = xn - NXW'(sq_s);
  assign ysg  = sq5.y[YW-1];
  assign p1   = !sq5.dneg && (n1 != '0) && (n1[NXW-1] == ysg);
  assign p2   = !sq5.dneg && (n2 != '0) && (n2[NXW-1] == ysg);

  // both roots on the side of 2a: the smaller magnitude wins
  always_comb begin
    if (sq5.lin) begin
      fnd5    = sq5.bok && (xn != '0) && (xn[NXW-1] == ysg);
      num_sel = xn;
    end else begin
      fnd5 = p1 || p2;
      if (p1 && p2) begin
        num_sel = ysg ? n1 : n2;
      end else if (p1) begin
        num_sel = n1;
      end else begin
        num_sel = n2;
      end
    end
  end

  assign num_abs = num_sel[NXW-1] ? NXW'(-num_sel) : NXW'(num_sel);
  assign den_abs = ysg ? YW'(-sq5.y) : YW'(sq5.y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= sq_vld[RTW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fnd5_r <= fnd5;
      num5_r <= num_abs;
      den5_r <= den_abs;
    end
  end

  // saturation check and divider setup
  logic           s6_vld_r;
  logic [RW-1:0]  n6_r, d6_r;
  dv_side_t       dv6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n6_r        <= RW'(num5_r);
      d6_r        <= RW'(den5_r) << (HW - 1);
      dv6_r.found <= fnd5_r;
      dv6_r.sat   <= SATW'(num5_r) >= (SATW'(den5_r) << HW);
    end
  end

  // divider row
  logic           dv_vld [0:HW];
  logic [RW-1:0]  dv_n   [0:HW];
  logic [RW-1:0]  dv_d   [0:HW];
  logic [HW-1:0]  dv_q   [0:HW];
  dv_side_t       dv_sd  [0:HW];

  assign dv_vld[0] = s6_vld_r;
  assign dv_n[0]   = n6_r;
  assign dv_d[0]   = d6_r;
  assign dv_q[0]   = '0;
  assign dv_sd[0]  = dv6_r;

  for (genvar k = 0; k < HW; k++) begin : g_div
    its_div_cell #(.RW(RW), .SW($bits(dv_side_t))) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(dv_vld[k]), .n_i(dv_n[k]), .d_i(dv_d[k]), .q_i(dv_q[k]),
      .side_i(dv_sd[k]),
      .vld_o(dv_vld[k+1]), .n_o(dv_n[k+1]), .d_o(dv_d[k+1]), .q_o(dv_q[k+1]),
      .side_o(dv_sd[k+1]));
  end

  // output word register
  dv_side_t       dvo;
  logic           out_vld_r;
  logic           fnd_r;
  logic [HW-1:0]  hit_r, hit_nxt;

  assign dvo     = dv_sd[HW];
  assign hit_nxt = !dvo.found ? '0 : (dvo.sat ? its_pkg::HIT_MAX : dv_q[HW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld[HW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fnd_r <= dvo.found;
      hit_r <= hit_nxt;
    end
  end

  assign out_word.valid          = out_vld_r;
  assign out_word.solution_found = fnd_r;
  assign out_word.hit_time       = hit_r;
endmodule
